### hw/rtl/knot_pkg.sv
// ----------------------------------------------------------------------------
// knot_pkg
// Shared types and constants for the k-nearest-to-origin tracker.
// ----------------------------------------------------------------------------
package knot_pkg;

   localparam int MAX_KEEP   = 16;
   localparam int COORD_BITS = 16;
   localparam int IDX_BITS   = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
   localparam int FILL_BITS  = $clog2(MAX_KEEP + 1);
   localparam int DIST_BITS  = 2 * COORD_BITS + 1;
   localparam int KEEP_BITS  = 5;
   localparam int OUT_BITS   = 16;
   localparam int ODIST_BITS = 32;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic [DIST_BITS-1:0]         dist_type;
   typedef logic [IDX_BITS-1:0]          idx_type;
   typedef logic [FILL_BITS-1:0]         fill_type;

   typedef struct packed {
      logic load;      // capture transaction, compute distance
      logic restart;   // clear fill
      logic insert;    // append or replace
      logic scan_init; // begin worst search
      logic scan_step; // compare one slot
   } cmd_type;

   typedef struct packed {
      logic append;    // store not full for current k
      logic scan_done;
      logic mode;
   } stat_type;

   // a orders strictly above b
   function automatic logic orders_above(dist_type da, coord_type xa, coord_type ya,
                                         dist_type db, coord_type xb, coord_type yb);
      if (da != db) return da > db;
      if (xa != xb) return xa > xb;
      return ya > yb;
   endfunction

endpackage

### hw/rtl/knot_ctrl.sv
// ----------------------------------------------------------------------------
// knot_ctrl
// Sequencer: load, optional replace after worst scan, report scan, output.
// ----------------------------------------------------------------------------
module knot_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  logic              req_restart,
   output knot_pkg::cmd_type cmd,
   input  knot_pkg::stat_type stat
);
   import knot_pkg::*;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_PRE  = 3'd1; // scan worst before replace
   localparam logic [2:0] S_INS  = 3'd2;
   localparam logic [2:0] S_RPT  = 3'd3; // scan worst for report
   localparam logic [2:0] S_OUT  = 3'd4;
   localparam logic [2:0] S_SCI  = 3'd5; // start report scan

   logic [2:0] state_ff, state_in;
   logic       req_fire;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load    = 1'b1;
               cmd.restart = req_restart;
               state_in    = S_INS;
            end
         end
         S_INS: begin
            if (stat.append) begin
               cmd.insert = 1'b1;
               state_in = stat.mode ? S_SCI : S_IDLE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in = S_PRE;
            end
         end
         S_PRE: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) begin
               cmd.insert = 1'b1;
               state_in = stat.mode ? S_SCI : S_IDLE;
            end
         end
         S_SCI: begin
            cmd.scan_init = 1'b1;
            state_in = S_RPT;
         end
         S_RPT: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

endmodule

### hw/rtl/knot_datapath.sv
// ----------------------------------------------------------------------------
// knot_datapath
// Point store, distance multiply, serial worst-slot scan, result register.
// ----------------------------------------------------------------------------
module knot_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic               req_mode,
   input  knot_pkg::cmd_type  cmd,
   output knot_pkg::stat_type stat,
   output logic signed [15:0] rsp_kth_x,
   output logic signed [15:0] rsp_kth_y,
   output logic [31:0]        rsp_kth_distance,
   output logic               rsp_set_full
);
   import knot_pkg::*;

   logic [KEEP_BITS-1:0] keep_ff;
   fill_type             k_eff;
   fill_type             fill_ff, fill_in;
   coord_type            x_ff, y_ff;
   logic                 mode_ff;
   coord_type            kx [MAX_KEEP];
   coord_type            ky [MAX_KEEP];
   dist_type             kd [MAX_KEEP];
   dist_type             dist_new;
   logic [2*COORD_BITS-1:0] sx, sy;
   logic signed [2*COORD_BITS-1:0] px_sq, py_sq;
   idx_type              scan_ff, worst_ff;
   idx_type              wnext;
   logic [FILL_BITS:0]   scan_nxt;
   logic                 better;

   always_comb begin
      if (keep_ff == '0) k_eff = fill_type'(1);
      else if ({1'b0, keep_ff} > (KEEP_BITS+1)'(MAX_KEEP)) k_eff = fill_type'(MAX_KEEP);
      else k_eff = fill_type'(keep_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) keep_ff <= KEEP_BITS'(16);
      else if (csr_write_enable) keep_ff <= csr_write_data;
   end

   assign px_sq = (2*COORD_BITS)'(req_point_x) * (2*COORD_BITS)'(req_point_x);
   assign py_sq = (2*COORD_BITS)'(req_point_y) * (2*COORD_BITS)'(req_point_y);

   // one 16x16 signed product per coordinate, registered before the add
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff    <= coord_type'(req_point_x);
         y_ff    <= coord_type'(req_point_y);
         mode_ff <= req_mode;
         sx      <= $unsigned(px_sq);
         sy      <= $unsigned(py_sq);
      end
   end
   assign dist_new = {1'b0, sx} + {1'b0, sy};

   assign stat.append = (fill_ff < k_eff) && (fill_ff < fill_type'(MAX_KEEP));
   assign stat.mode   = mode_ff;

   always_comb begin
      fill_in = fill_ff;
      if (cmd.load && cmd.restart) fill_in = '0;
      else if (cmd.insert && stat.append) fill_in = fill_ff + fill_type'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) fill_ff <= '0;
      else       fill_ff <= fill_in;
   end

   // serial worst scan, one slot per cycle
   assign scan_nxt = (FILL_BITS+1)'(scan_ff) + (FILL_BITS+1)'(1);
   assign better = orders_above(kd[scan_ff], kx[scan_ff], ky[scan_ff],
                                kd[worst_ff], kx[worst_ff], ky[worst_ff]);
   assign stat.scan_done = (scan_nxt >= (FILL_BITS+1)'(fill_ff));
   assign wnext = better ? scan_ff : worst_ff;

   always_ff @(posedge clock) begin
      if (cmd.scan_init) begin
         scan_ff  <= '0;
         worst_ff <= '0;
      end else if (cmd.scan_step) begin
         worst_ff <= wnext;
         if (!stat.scan_done) scan_ff <= idx_type'(scan_nxt);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.insert) begin
         if (stat.append) begin
            kx[idx_type'(fill_ff)] <= x_ff;
            ky[idx_type'(fill_ff)] <= y_ff;
            kd[idx_type'(fill_ff)] <= dist_new;
         end else if (orders_above(kd[wnext], kx[wnext], ky[wnext],
                                   dist_new, x_ff, y_ff)) begin
            kx[wnext] <= x_ff;
            ky[wnext] <= y_ff;
            kd[wnext] <= dist_new;
         end
      end
   end

   // result register, written on the last step of every worst scan (pre-replace and report)
   always_ff @(posedge clock) begin
      if (cmd.scan_step && stat.scan_done) begin
         rsp_kth_x        <= 16'(kx[wnext]);
         rsp_kth_y        <= 16'(ky[wnext]);
         rsp_kth_distance <= kd[wnext][ODIST_BITS-1:0];
         rsp_set_full     <= (fill_ff >= k_eff);
      end
   end

endmodule

### hw/rtl/k_nearest_to_origin_tracker_top.sv
// ----------------------------------------------------------------------------
// k_nearest_to_origin_tracker_top
// Keeps the k points nearest the origin and, in mode 1, reports the k-th nearest.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  req     | req_valid/req_ready   | point_x, point_y, mode, restart
//  rsp     | rsp_valid/rsp_ready   | kth_x, kth_y, kth_distance, set_full
//  csr     | csr_write_enable      | csr_write_data (keep_count)
//
// Load point: accepted in idle, then inserted directly while the store is filling,
// else after a serial worst-slot scan over the store. In mode 1 a report
// scan follows, then the response waits in its register until rsp_ready.
// Synchronous reset clears fill and sets keep_count to 16.
// One transaction in flight; req_ready is low until the transaction completes and, in mode 1, its response is taken.
module k_nearest_to_origin_tracker_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic               req_mode,
   input  logic               req_restart,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_kth_x,
   output logic signed [15:0] rsp_kth_y,
   output logic [31:0]        rsp_kth_distance,
   output logic               rsp_set_full
);
   import knot_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   knot_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .req_restart, .cmd, .stat
   );

   knot_datapath u_dp (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_point_x, .req_point_y, .req_mode, .cmd, .stat,
      .rsp_kth_x, .rsp_kth_y, .rsp_kth_distance, .rsp_set_full
   );

endmodule

### hw/rtl/knot_checker.sv
// ----------------------------------------------------------------------------
// knot_checker
// Port-level checks for the tracker, bound to the top level.
// ----------------------------------------------------------------------------
module knot_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_mode,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_kth_distance
);
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("accept while response pending");

   a_no_mode0_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_mode) |=> !rsp_valid)
      else $error("silent load produced a response");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kth_distance)))
      else $error("response dropped or changed");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid) else $error("response after reset");
endmodule

bind k_nearest_to_origin_tracker_top knot_checker u_knot_checker (
   .clock, .reset, .req_valid, .req_ready, .req_mode,
   .rsp_valid, .rsp_ready, .rsp_kth_distance
);
